// ===== rtl/jnls_pkg.sv =====
// package for the json number literal scanner: types, codes and constants
`timescale 1ns / 1ps
package jnls_pkg;

    localparam int ACCUM_BITS_DEFAULT = 64;
    localparam int EXP_BITS = 31;
    localparam int FCNT_BITS = 8;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_UP = 8'h45;
    localparam logic [7:0] CH_E_LO = 8'h65;
    localparam logic [7:0] CH_X_UP = 8'h58;
    localparam logic [7:0] CH_X_LO = 8'h78;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_A_UP = 8'h41;
    localparam logic [7:0] CH_A_LO = 8'h61;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_BAD_INT = 3'd1,
        ST_LEAD_ZERO = 3'd2,
        ST_BAD_FRAC = 3'd3,
        ST_BAD_EXP = 3'd4,
        ST_BAD_HEX = 3'd5,
        ST_BAD_OCT = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        RK_DEC = 2'd0,
        RK_OCT = 2'd1,
        RK_HEX = 2'd2
    } t_radix;

    typedef enum logic [3:0] {
        PH_IDLE, PH_SIGN, PH_INT, PH_OCT, PH_HEX0, PH_HEX,
        PH_POINT, PH_FRAC, PH_EMARK, PH_ESIGN, PH_EXP
    } t_phase;

    localparam logic [1:0] CFG_OCTAL = 2'd0;
    localparam logic [1:0] CFG_HEX = 2'd1;
    localparam logic [1:0] CFG_TPOINT = 2'd2;

    // classified character, produced by the front end
    typedef struct packed {
        logic       start;
        logic       at_end;
        logic       is_dig;
        logic       is_hex;
        logic [3:0] val;
        logic       is_minus;
        logic       is_plus;
        logic       is_point;
        logic       is_e;
        logic       is_x;
    } t_cls;

endpackage

// ===== rtl/jnls_front.sv =====
// front end: accepts characters, classifies them and queues them
`timescale 1ns / 1ps
module jnls_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [7:0]     i_ch,
    input  logic           i_start_req,
    input  logic           i_at_end,
    output logic           o_valid,
    input  logic           i_pop,
    output jnls_pkg::t_cls o_cls
);
    jnls_pkg::t_cls w_cls;
    jnls_pkg::t_cls r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;

    always_comb begin
        w_cls = '0;
        w_cls.start = i_start_req;
        w_cls.at_end = i_at_end;
        if (i_ch >= jnls_pkg::CH_ZERO && i_ch <= 8'h39) begin
            w_cls.is_dig = 1'b1;
            w_cls.is_hex = 1'b1;
            w_cls.val = 4'(i_ch - jnls_pkg::CH_ZERO);
        end else if (i_ch >= jnls_pkg::CH_A_UP && i_ch <= 8'h46) begin
            w_cls.is_hex = 1'b1;
            w_cls.val = 4'(i_ch - jnls_pkg::CH_A_UP + 8'd10);
        end else if (i_ch >= jnls_pkg::CH_A_LO && i_ch <= 8'h66) begin
            w_cls.is_hex = 1'b1;
            w_cls.val = 4'(i_ch - jnls_pkg::CH_A_LO + 8'd10);
        end
        w_cls.is_minus = i_ch == jnls_pkg::CH_MINUS;
        w_cls.is_plus = i_ch == jnls_pkg::CH_PLUS;
        w_cls.is_point = i_ch == jnls_pkg::CH_POINT;
        w_cls.is_e = i_ch == jnls_pkg::CH_E_UP || i_ch == jnls_pkg::CH_E_LO;
        w_cls.is_x = i_ch == jnls_pkg::CH_X_UP || i_ch == jnls_pkg::CH_X_LO;
        if (i_at_end) begin
            w_cls.is_dig = 1'b0;
            w_cls.is_hex = 1'b0;
        end
    end

    assign o_stall = r_cnt == 2'd2;
    assign w_push = i_valid && !o_stall;
    assign o_valid = r_cnt != 2'd0;
    assign o_cls = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cls;
        end
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_pop);
        end
    end
endmodule

// ===== rtl/jnls_back.sv =====
// back end: number scanning state machine and result register
`timescale 1ns / 1ps
module jnls_back #(
    parameter int ACCUM_BITS = jnls_pkg::ACCUM_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_octal_enable,
    input  logic                  i_hex_enable,
    input  logic                  i_trailing_point_enable,
    input  logic                  i_valid,
    output logic                  o_pop,
    input  jnls_pkg::t_cls        i_cls,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic                  o_char_used,
    output logic                  o_negative,
    output logic [1:0]            o_radix_kind,
    output logic [ACCUM_BITS-1:0] o_int_part,
    output logic                  o_has_fraction,
    output logic [ACCUM_BITS-1:0] o_frac_part,
    output logic [7:0]            o_frac_digits,
    output logic                  o_has_exponent,
    output logic                  o_exp_negative,
    output logic [30:0]           o_exponent
);
    localparam logic [30:0] EXP_MAX = '1;

    jnls_pkg::t_phase      r_ph, n_ph;
    logic                  r_sign, n_sign;
    logic [1:0]            r_idc, n_idc;
    logic [ACCUM_BITS-1:0] r_int, n_int, r_frac, n_frac;
    logic [7:0]            r_fc, n_fc;
    logic                  r_es, n_es, r_ff, n_ff, r_ef, n_ef;
    logic [30:0]           r_exp, n_exp;
    logic                  w_emit;
    jnls_pkg::t_status     w_st;
    logic                  w_free;
    logic [34:0]           w_e10;
    logic [1:0]            w_idc;
    logic [3:0]            d;

    assign w_free = !o_valid || !i_stall;
    assign o_pop = i_valid && w_free;
    assign d = i_cls.val;
    assign w_e10 = {4'd0, r_exp} * 35'd10 + 35'(d);
    assign w_idc = (r_idc < 2'd3) ? r_idc + 2'd1 : r_idc;

    always_comb begin
        n_ph = r_ph; n_sign = r_sign; n_idc = r_idc; n_int = r_int;
        n_frac = r_frac; n_fc = r_fc; n_es = r_es; n_ff = r_ff;
        n_ef = r_ef; n_exp = r_exp;
        w_emit = 1'b0;
        w_st = jnls_pkg::ST_OK;
        if (i_cls.start) begin
            n_sign = 1'b0; n_idc = '0; n_int = '0; n_frac = '0; n_fc = '0;
            n_es = 1'b0; n_ff = 1'b0; n_ef = 1'b0; n_exp = '0;
            n_ph = jnls_pkg::PH_IDLE;
            if (i_cls.at_end || !(i_cls.is_minus || i_cls.is_dig)) begin
                w_emit = 1'b1; w_st = jnls_pkg::ST_BAD_INT;
            end else if (i_cls.is_minus) begin
                n_sign = 1'b1; n_ph = jnls_pkg::PH_SIGN;
            end else begin
                n_idc = 2'd1; n_int = ACCUM_BITS'(d); n_ph = jnls_pkg::PH_INT;
            end
        end else begin
            unique case (r_ph)
                jnls_pkg::PH_IDLE: ;
                jnls_pkg::PH_SIGN, jnls_pkg::PH_INT: begin
                    if (i_cls.is_dig) begin
                        n_idc = w_idc;
                        if (w_idc == 2'd2 && r_int == '0) begin
                            if (!i_octal_enable) begin
                                w_emit = 1'b1; w_st = jnls_pkg::ST_LEAD_ZERO;
                            end else if (d > 4'd7) begin
                                w_emit = 1'b1; w_st = jnls_pkg::ST_BAD_OCT;
                            end else begin
                                n_int = ACCUM_BITS'(d); n_ph = jnls_pkg::PH_OCT;
                            end
                        end else begin
                            n_int = {r_int[ACCUM_BITS-4:0], 3'b000}
                                  + {r_int[ACCUM_BITS-2:0], 1'b0} + ACCUM_BITS'(d);
                            n_ph = jnls_pkg::PH_INT;
                        end
                    end else if (r_ph == jnls_pkg::PH_SIGN) begin
                        w_emit = 1'b1; w_st = jnls_pkg::ST_BAD_INT;
                    end else if (i_cls.at_end) begin
                        w_emit = 1'b1;
                    end else if (i_cls.is_point) begin
                        n_ph = jnls_pkg::PH_POINT;
                    end else if (r_idc == 2'd1 && r_int == '0 && i_hex_enable
                                 && i_cls.is_x) begin
                        n_ph = jnls_pkg::PH_HEX0;
                    end else if (i_cls.is_e) begin
                        n_ph = jnls_pkg::PH_EMARK;
                    end else begin
                        w_emit = 1'b1;
                    end
                end
                jnls_pkg::PH_OCT: begin
                    if (!i_cls.is_dig) begin
                        w_emit = 1'b1;
                    end else if (d > 4'd7) begin
                        w_emit = 1'b1; w_st = jnls_pkg::ST_BAD_OCT;
                    end else begin
                        n_int = {r_int[ACCUM_BITS-4:0], 3'b000} | ACCUM_BITS'(d);
                    end
                end
                jnls_pkg::PH_HEX0, jnls_pkg::PH_HEX: begin
                    if (!i_cls.is_hex) begin
                        w_emit = 1'b1;
                        w_st = (r_ph == jnls_pkg::PH_HEX) ? jnls_pkg::ST_OK
                                                          : jnls_pkg::ST_BAD_HEX;
                    end else begin
                        n_int = {r_int[ACCUM_BITS-5:0], d};
                        n_ph = jnls_pkg::PH_HEX;
                    end
                end
                jnls_pkg::PH_POINT, jnls_pkg::PH_FRAC: begin
                    if (r_ph == jnls_pkg::PH_POINT && !i_cls.is_dig) begin
                        w_emit = 1'b1;
                        w_st = i_trailing_point_enable ? jnls_pkg::ST_OK
                                                       : jnls_pkg::ST_BAD_FRAC;
                    end else if (i_cls.is_dig) begin
                        n_ff = 1'b1;
                        n_frac = {r_frac[ACCUM_BITS-4:0], 3'b000}
                               + {r_frac[ACCUM_BITS-2:0], 1'b0} + ACCUM_BITS'(d);
                        if (r_fc != 8'hFF) begin
                            n_fc = r_fc + 8'd1;
                        end
                        n_ph = jnls_pkg::PH_FRAC;
                    end else if (!i_cls.at_end && i_cls.is_e) begin
                        n_ph = jnls_pkg::PH_EMARK;
                    end else begin
                        w_emit = 1'b1;
                    end
                end
                jnls_pkg::PH_EMARK, jnls_pkg::PH_ESIGN, jnls_pkg::PH_EXP: begin
                    if (r_ph == jnls_pkg::PH_EMARK && !i_cls.at_end
                        && (i_cls.is_plus || i_cls.is_minus)) begin
                        n_es = i_cls.is_minus;
                        n_ph = jnls_pkg::PH_ESIGN;
                    end else if (!i_cls.is_dig) begin
                        w_emit = 1'b1;
                        w_st = (r_ph == jnls_pkg::PH_EXP) ? jnls_pkg::ST_OK
                                                          : jnls_pkg::ST_BAD_EXP;
                    end else begin
                        n_ef = 1'b1;
                        n_exp = (w_e10 > 35'(EXP_MAX)) ? EXP_MAX : w_e10[30:0];
                        n_ph = jnls_pkg::PH_EXP;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            o_status <= w_st;
            o_char_used <= 1'b0;
            if (w_st == jnls_pkg::ST_OK) begin
                o_negative <= r_sign;
                o_radix_kind <= (r_ph == jnls_pkg::PH_OCT) ? jnls_pkg::RK_OCT :
                                (r_ph == jnls_pkg::PH_HEX) ? jnls_pkg::RK_HEX :
                                jnls_pkg::RK_DEC;
                o_int_part <= r_int;
                o_has_fraction <= r_ff;
                o_frac_part <= r_frac;
                o_frac_digits <= r_fc;
                o_has_exponent <= r_ef;
                o_exp_negative <= r_es;
                o_exponent <= r_exp;
            end else begin
                o_negative <= 1'b0;
                o_radix_kind <= jnls_pkg::RK_DEC;
                o_int_part <= '0;
                o_has_fraction <= 1'b0;
                o_frac_part <= '0;
                o_frac_digits <= '0;
                o_has_exponent <= 1'b0;
                o_exp_negative <= 1'b0;
                o_exponent <= '0;
            end
        end
        if (!i_rst_n) begin
            o_valid <= 1'b0;
            r_ph <= jnls_pkg::PH_IDLE;
            r_sign <= 1'b0; r_idc <= '0; r_int <= '0; r_frac <= '0; r_fc <= '0;
            r_es <= 1'b0; r_ff <= 1'b0; r_ef <= 1'b0; r_exp <= '0;
        end else begin
            if (w_free) begin
                o_valid <= o_pop && w_emit;
            end
            if (o_pop) begin
                if (w_emit) begin
                    r_ph <= jnls_pkg::PH_IDLE;
                    r_sign <= 1'b0; r_idc <= '0; r_int <= '0; r_frac <= '0;
                    r_fc <= '0; r_es <= 1'b0; r_ff <= 1'b0; r_ef <= 1'b0;
                    r_exp <= '0;
                end else begin
                    r_ph <= n_ph; r_sign <= n_sign; r_idc <= n_idc;
                    r_int <= n_int; r_frac <= n_frac; r_fc <= n_fc;
                    r_es <= n_es; r_ff <= n_ff; r_ef <= n_ef; r_exp <= n_exp;
                end
            end
        end
    end
endmodule

// ===== rtl/json_number_literal_scanner.sv =====
// top level of the json number literal scanner
// usage:
//   input channel: one character per transaction (i_ch, i_start_req,
//   i_at_end) with i_valid / o_stall; start_req opens a new literal
//   output channel: at most one result transaction per input, carrying
//   status and the literal parts, with o_valid / i_stall
//   configuration: i_cfg_we, i_cfg_index, i_cfg_data write the octal,
//   hex and trailing point enables; write only while the block is idle
// latency: a result is presented one cycle after the terminating character
// is accepted (the queue entry is scanned and the result registered at the
// next edge)
// throughput: one character per cycle, set by the single cycle update of
// the scan state machine and its 64 bit multiply-by-ten accumulators
// reset: clears the queue, the scan state and the enables; no literal open
// stall: a held result keeps the scanner waiting while the two entry queue
// fills; after that o_stall goes high until the result is taken
`timescale 1ns / 1ps
module json_number_literal_scanner #(
    parameter int ACCUM_BITS = jnls_pkg::ACCUM_BITS_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic                  i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_ch,
    input  logic                  i_start_req,
    input  logic                  i_at_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic                  o_char_used,
    output logic                  o_negative,
    output logic [1:0]            o_radix_kind,
    output logic [ACCUM_BITS-1:0] o_int_part,
    output logic                  o_has_fraction,
    output logic [ACCUM_BITS-1:0] o_frac_part,
    output logic [7:0]            o_frac_digits,
    output logic                  o_has_exponent,
    output logic                  o_exp_negative,
    output logic [30:0]           o_exponent
);
    logic           r_oct, r_hex, r_tp;
    logic           w_qv, w_pop;
    jnls_pkg::t_cls w_cls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct <= 1'b0;
            r_hex <= 1'b0;
            r_tp <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                jnls_pkg::CFG_OCTAL:  r_oct <= i_cfg_data;
                jnls_pkg::CFG_HEX:    r_hex <= i_cfg_data;
                jnls_pkg::CFG_TPOINT: r_tp <= i_cfg_data;
                default: ;
            endcase
        end
    end

    jnls_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_ch(i_ch), .i_start_req(i_start_req), .i_at_end(i_at_end),
        .o_valid(w_qv), .i_pop(w_pop), .o_cls(w_cls)
    );

    jnls_back #(.ACCUM_BITS(ACCUM_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_octal_enable(r_oct),
        .i_hex_enable(r_hex), .i_trailing_point_enable(r_tp),
        .i_valid(w_qv), .o_pop(w_pop), .i_cls(w_cls),
        .o_valid(o_valid), .i_stall(i_stall), .o_status(o_status),
        .o_char_used(o_char_used), .o_negative(o_negative),
        .o_radix_kind(o_radix_kind), .o_int_part(o_int_part),
        .o_has_fraction(o_has_fraction), .o_frac_part(o_frac_part),
        .o_frac_digits(o_frac_digits), .o_has_exponent(o_has_exponent),
        .o_exp_negative(o_exp_negative), .o_exponent(o_exponent)
    );
endmodule

// ===== tb/tb_json_number_literal_scanner.sv =====
// testbench for the json number literal scanner: random and directed literals
`timescale 1ns / 1ps
module tb_json_number_literal_scanner;

    typedef struct {
        logic [2:0]  status;
        logic        char_used;
        logic        negative;
        logic [1:0]  radix_kind;
        logic [63:0] int_part;
        logic        has_fraction;
        logic [63:0] frac_part;
        logic [7:0]  frac_digits;
        logic        has_exponent;
        logic        exp_negative;
        logic [30:0] exponent;
    } t_literal;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic        cfg_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        dut_stall;
    logic [7:0]  ch = '0;
    logic        start_req = 1'b0;
    logic        at_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  status;
    logic        char_used, negative, has_fraction, has_exponent, exp_negative;
    logic [1:0]  radix_kind;
    logic [63:0] int_part, frac_part;
    logic [7:0]  frac_digits;
    logic [30:0] exponent;

    t_literal literal_queue[$];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  char_count = 0;
    bit  out_random_stall = 1'b1;

    // scanner shadow state
    jnls_pkg::t_phase phase;
    logic        en_oct, en_hex, en_tp;
    logic        sgn, esgn, fflag, eflag;
    logic [1:0]  icnt;
    logic [63:0] iacc, facc;
    logic [7:0]  fcnt;
    logic [30:0] eacc;

    always #5 clk = ~clk;

    json_number_literal_scanner i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(dut_stall),
        .i_ch(ch), .i_start_req(start_req), .i_at_end(at_end),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(status), .o_char_used(char_used), .o_negative(negative),
        .o_radix_kind(radix_kind), .o_int_part(int_part),
        .o_has_fraction(has_fraction), .o_frac_part(frac_part),
        .o_frac_digits(frac_digits), .o_has_exponent(has_exponent),
        .o_exp_negative(exp_negative), .o_exponent(exponent)
    );

    function automatic bit dec_char(logic [7:0] c);
        return c >= jnls_pkg::CH_ZERO && c <= 8'h39;
    endfunction

    function automatic logic [3:0] dec_val(logic [7:0] c);
        return 4'(c - jnls_pkg::CH_ZERO);
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (dec_char(c)) return int'(c) - int'(jnls_pkg::CH_ZERO);
        if (c >= jnls_pkg::CH_A_UP && c <= 8'h46)
            return int'(c) - int'(jnls_pkg::CH_A_UP) + 10;
        if (c >= jnls_pkg::CH_A_LO && c <= 8'h66)
            return int'(c) - int'(jnls_pkg::CH_A_LO) + 10;
        return -1;
    endfunction

    task automatic clear_scan();
        phase = jnls_pkg::PH_IDLE;
        sgn = 1'b0; icnt = '0; fcnt = '0; esgn = 1'b0; eacc = '0;
        fflag = 1'b0; eflag = 1'b0; iacc = '0; facc = '0;
    endtask

    task automatic push_literal(jnls_pkg::t_status st);
        t_literal r;
        r = '{default: '0};
        r.status = st;
        if (st == jnls_pkg::ST_OK) begin
            r.negative = sgn;
            r.radix_kind = phase == jnls_pkg::PH_OCT ? jnls_pkg::RK_OCT :
                           (phase == jnls_pkg::PH_HEX ? jnls_pkg::RK_HEX : jnls_pkg::RK_DEC);
            r.int_part = iacc;
            r.has_fraction = fflag;
            r.frac_part = facc;
            r.frac_digits = fcnt;
            r.has_exponent = eflag;
            r.exp_negative = esgn;
            r.exponent = eacc;
        end
        literal_queue.push_back(r);
        clear_scan();
    endtask

    task automatic take_int_digit(logic [3:0] d);
        if (icnt < 2'd3) icnt++;
        if (icnt == 2'd2 && iacc == '0) begin
            if (!en_oct) push_literal(jnls_pkg::ST_LEAD_ZERO);
            else if (d > 4'd7) push_literal(jnls_pkg::ST_BAD_OCT);
            else begin
                iacc = 64'(d);
                phase = jnls_pkg::PH_OCT;
            end
        end else begin
            iacc = iacc * 64'd10 + 64'(d);
            phase = jnls_pkg::PH_INT;
        end
    endtask

    task automatic end_or_exp(logic [7:0] c);
        if (c == jnls_pkg::CH_E_UP || c == jnls_pkg::CH_E_LO) phase = jnls_pkg::PH_EMARK;
        else push_literal(jnls_pkg::ST_OK);
    endtask

    task automatic frac_step(logic [7:0] c, logic e);
        if (e) push_literal(jnls_pkg::ST_OK);
        else if (!dec_char(c)) end_or_exp(c);
        else begin
            facc = facc * 64'd10 + 64'(dec_val(c));
            if (fcnt < 8'd255) fcnt++;
            phase = jnls_pkg::PH_FRAC;
        end
    endtask

    task automatic exp_step(logic [7:0] c, logic e);
        logic [63:0] v;
        if (e || !dec_char(c)) push_literal(jnls_pkg::ST_OK);
        else begin
            v = 64'(eacc) * 64'd10 + 64'(dec_val(c));
            eacc = v > 64'h7FFFFFFF ? 31'h7FFFFFFF : v[30:0];
            phase = jnls_pkg::PH_EXP;
        end
    endtask

    task automatic predict_scan(logic [7:0] c, logic s, logic e);
        int h;
        if (s) begin
            clear_scan();
            if (e) push_literal(jnls_pkg::ST_BAD_INT);
            else if (c == jnls_pkg::CH_MINUS) begin
                sgn = 1'b1;
                phase = jnls_pkg::PH_SIGN;
            end else if (dec_char(c)) take_int_digit(dec_val(c));
            else push_literal(jnls_pkg::ST_BAD_INT);
            return;
        end
        case (phase)
            jnls_pkg::PH_SIGN: begin
                if (e || !dec_char(c)) push_literal(jnls_pkg::ST_BAD_INT);
                else take_int_digit(dec_val(c));
            end
            jnls_pkg::PH_INT: begin
                if (e) push_literal(jnls_pkg::ST_OK);
                else if (dec_char(c)) take_int_digit(dec_val(c));
                else if (c == jnls_pkg::CH_POINT) phase = jnls_pkg::PH_POINT;
                else if (icnt == 2'd1 && iacc == '0 && en_hex
                         && (c == jnls_pkg::CH_X_UP || c == jnls_pkg::CH_X_LO))
                    phase = jnls_pkg::PH_HEX0;
                else end_or_exp(c);
            end
            jnls_pkg::PH_OCT: begin
                if (e || !dec_char(c)) push_literal(jnls_pkg::ST_OK);
                else if (dec_val(c) > 4'd7) push_literal(jnls_pkg::ST_BAD_OCT);
                else iacc = iacc * 64'd8 + 64'(dec_val(c));
            end
            jnls_pkg::PH_HEX0, jnls_pkg::PH_HEX: begin
                h = e ? -1 : hex_digit(c);
                if (h < 0) begin
                    push_literal(phase == jnls_pkg::PH_HEX ? jnls_pkg::ST_OK
                                                           : jnls_pkg::ST_BAD_HEX);
                end else begin
                    iacc = iacc * 64'd16 + 64'(h);
                    phase = jnls_pkg::PH_HEX;
                end
            end
            jnls_pkg::PH_POINT: begin
                if (e || !dec_char(c))
                    push_literal(en_tp ? jnls_pkg::ST_OK : jnls_pkg::ST_BAD_FRAC);
                else begin
                    fflag = 1'b1;
                    frac_step(c, e);
                end
            end
            jnls_pkg::PH_FRAC: frac_step(c, e);
            jnls_pkg::PH_EMARK: begin
                if (e) push_literal(jnls_pkg::ST_BAD_EXP);
                else if (c == jnls_pkg::CH_PLUS || c == jnls_pkg::CH_MINUS) begin
                    esgn = c == jnls_pkg::CH_MINUS;
                    phase = jnls_pkg::PH_ESIGN;
                end else if (!dec_char(c)) push_literal(jnls_pkg::ST_BAD_EXP);
                else begin
                    eflag = 1'b1;
                    exp_step(c, e);
                end
            end
            jnls_pkg::PH_ESIGN: begin
                if (e || !dec_char(c)) push_literal(jnls_pkg::ST_BAD_EXP);
                else begin
                    eflag = 1'b1;
                    exp_step(c, e);
                end
            end
            jnls_pkg::PH_EXP: exp_step(c, e);
            default: ;
        endcase
    endtask

    // output side: random stall while out_random_stall is set, check on each accepted transaction
    always @(negedge clk) begin
        if (!out_random_stall) out_stall <= 1'b0;
        else if ($urandom_range(0, 9) < 2) out_stall <= 1'b1;
        else if ($urandom_range(0, 99) == 0) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(0, 99) < 3) ? out_stall : 1'b0;
    end

    always @(posedge clk) begin
        t_literal x;
        if (rst_n && out_valid && !out_stall) begin
            if (literal_queue.size() == 0) begin
                $error("result with none expected");
                error_count++;
            end else begin
                x = literal_queue.pop_front();
                if (status !== x.status) begin
                    $error("status exp %0d got %0d", x.status, status); error_count++; end
                if (char_used !== x.char_used) begin
                    $error("char_used exp %0d got %0d", x.char_used, char_used); error_count++; end
                if (negative !== x.negative) begin
                    $error("negative exp %0d got %0d", x.negative, negative); error_count++; end
                if (radix_kind !== x.radix_kind) begin
                    $error("radix_kind exp %0d got %0d", x.radix_kind, radix_kind); error_count++; end
                if (int_part !== x.int_part) begin
                    $error("int_part exp %0h got %0h", x.int_part, int_part); error_count++; end
                if (has_fraction !== x.has_fraction) begin
                    $error("has_fraction exp %0d got %0d", x.has_fraction, has_fraction);
                    error_count++;
                end
                if (frac_part !== x.frac_part) begin
                    $error("frac_part exp %0h got %0h", x.frac_part, frac_part); error_count++; end
                if (frac_digits !== x.frac_digits) begin
                    $error("frac_digits exp %0d got %0d", x.frac_digits, frac_digits);
                    error_count++;
                end
                if (has_exponent !== x.has_exponent) begin
                    $error("has_exponent exp %0d got %0d", x.has_exponent, has_exponent);
                    error_count++;
                end
                if (exp_negative !== x.exp_negative) begin
                    $error("exp_negative exp %0d got %0d", x.exp_negative, exp_negative);
                    error_count++;
                end
                if (exponent !== x.exponent) begin
                    $error("exponent exp %0h got %0h", x.exponent, exponent); error_count++; end
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk) begin
        if ((in_valid && !dut_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_char(logic [7:0] c, logic s, logic e);
        int gap;
        if ($urandom_range(0, 3) == 0) begin
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        start_req <= s;
        at_end <= e;
        @(posedge clk);
        while (dut_stall) @(posedge clk);
        predict_scan(c, s, e);
        char_count++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (literal_queue.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            jnls_pkg::CFG_OCTAL: en_oct = v;
            jnls_pkg::CFG_HEX: en_hex = v;
            jnls_pkg::CFG_TPOINT: en_tp = v;
            default: ;
        endcase
    endtask

    task automatic send_text(string s, logic at_end_term);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == 0, 1'b0);
        send_char(8'h2C, 1'b0, at_end_term);
    endtask

    task automatic test_directed();
        send_text("-0", 1'b0);
        send_text("12.5e+3", 1'b1);
        send_text("01", 1'b0);
        send_text("0x1F", 1'b1);
        send_text("1.", 1'b0);
        send_text("1e", 1'b0);
        send_text("a", 1'b0);
        send_char(jnls_pkg::CH_ZERO, 1'b1, 1'b1);
        send_char(8'hFF, 1'b0, 1'b0);
        send_text("1.5E-99999999999", 1'b0);
        drain();
        write_cfg(jnls_pkg::CFG_OCTAL, 1'b1);
        write_cfg(jnls_pkg::CFG_HEX, 1'b1);
        write_cfg(jnls_pkg::CFG_TPOINT, 1'b1);
        send_text("0777", 1'b0);
        send_text("08", 1'b0);
        send_text("0Xfa", 1'b0);
        send_text("0xg", 1'b0);
        send_text("3.", 1'b1);
        send_text("-x", 1'b0);
        drain();
    endtask

    function automatic logic [7:0] rand_digit();
        return 8'(jnls_pkg::CH_ZERO + $urandom_range(0, 9));
    endfunction

    task automatic send_random_literal();
        int n;
        logic [7:0] t;
        if ($urandom_range(0, 1)) send_char(jnls_pkg::CH_MINUS, 1'b1, 1'b0);
        else send_char(rand_digit(), 1'b1, 1'b0);
        if ($urandom_range(0, 9) == 0) begin
            send_char(jnls_pkg::CH_ZERO, 1'b1, 1'b0);
            send_char($urandom_range(0, 1) ? jnls_pkg::CH_X_LO : jnls_pkg::CH_X_UP,
                      1'b0, 1'b0);
            n = $urandom_range(0, 18);
            repeat (n)
                send_char(8'(8'h61 + $urandom_range(0, 5) - ($urandom_range(0, 1) * 32)),
                          1'b0, 1'b0);
        end
        n = $urandom_range(0, 2) == 0 ? $urandom_range(0, 22) : $urandom_range(0, 4);
        repeat (n) send_char(rand_digit(), 1'b0, 1'b0);
        if ($urandom_range(0, 1)) begin
            send_char(jnls_pkg::CH_POINT, 1'b0, 1'b0);
            n = $urandom_range(0, 30) == 0 ? $urandom_range(250, 265) : $urandom_range(0, 21);
            repeat (n) send_char(rand_digit(), 1'b0, 1'b0);
        end
        if ($urandom_range(0, 1)) begin
            send_char($urandom_range(0, 1) ? jnls_pkg::CH_E_UP : jnls_pkg::CH_E_LO,
                      1'b0, 1'b0);
            case ($urandom_range(0, 2))
                0: send_char(jnls_pkg::CH_PLUS, 1'b0, 1'b0);
                1: send_char(jnls_pkg::CH_MINUS, 1'b0, 1'b0);
                default: ;
            endcase
            n = $urandom_range(0, 12);
            repeat (n) send_char(rand_digit(), 1'b0, 1'b0);
        end
        t = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            send_char(t, $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
        send_char(t, 1'b0, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random(int chars);
        int first;
        first = char_count;
        while (char_count - first < chars) begin
            if ($urandom_range(0, 9) == 0) begin
                send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)));
            end else begin
                send_random_literal();
            end
            if ($urandom_range(0, 60) == 0) begin
                // hold off until all results are back
                in_valid <= 1'b0;
                while (literal_queue.size() != 0) @(negedge clk);
            end
        end
        drain();
    endtask

    initial begin
        en_oct = 1'b0; en_hex = 1'b0; en_tp = 1'b0;
        clear_scan();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        for (int k = 0; k < 8; k++) begin
            write_cfg(jnls_pkg::CFG_OCTAL, k[0]);
            write_cfg(jnls_pkg::CFG_HEX, k[1]);
            write_cfg(jnls_pkg::CFG_TPOINT, k[2]);
            if (k == 3) out_random_stall = 1'b0;
            if (k == 5) out_random_stall = 1'b1;
            test_random(170);
        end
        if (error_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
